// File: design/psga_pkg.sv
// Shared types, codes and constants of the phase-synced gated amplifier.
package psga_pkg;

	// Field widths
	localparam int REQ_W    = 2;
	localparam int SAMPLE_W = 16;
	localparam int PHASE_W  = 16;
	localparam int GAIN_W   = 8;

	// Phase bits that take part in restart detection
	localparam int PHASE_INT_BITS  = 16;
	localparam int PHASE_FRAC_BITS = 16;
	localparam logic [PHASE_W-1:0] PHASE_INT_MASK = (PHASE_INT_BITS >= PHASE_W) ?
		{PHASE_W{1'b1}} : PHASE_W'((64'd1 << PHASE_INT_BITS) - 64'd1);
	localparam logic [PHASE_W-1:0] PHASE_FRAC_MASK = (PHASE_FRAC_BITS >= PHASE_W) ?
		{PHASE_W{1'b1}} : PHASE_W'((64'd1 << PHASE_FRAC_BITS) - 64'd1);

	// Request codes
	localparam logic [REQ_W-1:0] REQ_SAMPLE   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_GATE_ON  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_GATE_OFF = 2'd2;

	// Gate state codes
	localparam int GATE_W = 3;
	localparam logic [GATE_W-1:0] GATE_OFF         = 3'd0;
	localparam logic [GATE_W-1:0] GATE_TO_ON       = 3'd1;
	localparam logic [GATE_W-1:0] GATE_ON          = 3'd2;
	localparam logic [GATE_W-1:0] GATE_TO_OFF      = 3'd3;
	localparam logic [GATE_W-1:0] GATE_CHANGE_GAIN = 3'd4;

	// Scaling: |sample| * gain fits in 23 bits, quotient by 127 in 17 bits
	localparam int MAG_W   = 23;
	localparam int QUO_W   = 17;
	localparam int RECIP_W = 24;
	// ceil(2^30 / 127); exact for every dividend below 2^23
	localparam logic [RECIP_W-1:0] RECIP_127 = 24'd8454661;
	localparam int RECIP_SHIFT = 30;
	localparam int PROD_W = MAG_W + RECIP_W;

	localparam logic [QUO_W-1:0] POS_LIMIT = 17'd32767;
	localparam logic [QUO_W-1:0] NEG_LIMIT = 17'd32768;

	// Amplifier control handed from the gate logic to the datapath
	typedef struct packed {
		logic              en;
		logic [GAIN_W-1:0] gain;
	} amp_t;

endpackage

// File: design/psga_gate.sv
// Gate state machine, gain registers and phase restart detection.
module psga_gate (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic [psga_pkg::REQ_W-1:0]    req,
	input  logic [psga_pkg::PHASE_W-1:0]  phase_int,
	input  logic [psga_pkg::PHASE_W-1:0]  phase_frac,
	input  logic [psga_pkg::GAIN_W-1:0]   gain,
	output psga_pkg::amp_t                amp
);

	logic [psga_pkg::GATE_W-1:0]  state_q, state_d, state_r;
	logic [psga_pkg::GAIN_W-1:0]  active_gain_q, active_gain_d;
	logic [psga_pkg::GAIN_W-1:0]  pending_gain_q, pending_gain_d;
	logic [psga_pkg::PHASE_W-1:0] last_phase_q, last_phase_d;
	logic [psga_pkg::PHASE_W-1:0] pint;
	logic [psga_pkg::PHASE_W-1:0] pfrac;
	logic                         restart;

	assign pint    = phase_int & psga_pkg::PHASE_INT_MASK;
	assign pfrac   = phase_frac & psga_pkg::PHASE_FRAC_MASK;
	assign restart = ((pint == '0) && (pfrac == '0)) || (pint < last_phase_q);

	// Apply a phase restart to the current state
	always_comb begin
		state_r       = state_q;
		active_gain_d = active_gain_q;
		if (restart) begin
			if (state_q == psga_pkg::GATE_TO_ON || state_q == psga_pkg::GATE_CHANGE_GAIN) begin
				state_r       = psga_pkg::GATE_ON;
				active_gain_d = pending_gain_q;
			end else if (state_q == psga_pkg::GATE_TO_OFF) begin
				state_r = psga_pkg::GATE_OFF;
			end
		end
	end

	// Next state for each request type
	always_comb begin
		state_d        = state_q;
		pending_gain_d = pending_gain_q;
		last_phase_d   = last_phase_q;
		case (req)
			psga_pkg::REQ_GATE_ON: begin
				case (state_q)
					psga_pkg::GATE_OFF: begin
						pending_gain_d = gain;
						state_d        = psga_pkg::GATE_TO_ON;
					end
					psga_pkg::GATE_ON, psga_pkg::GATE_TO_OFF: begin
						pending_gain_d = gain;
						state_d        = psga_pkg::GATE_CHANGE_GAIN;
					end
					psga_pkg::GATE_TO_ON, psga_pkg::GATE_CHANGE_GAIN: begin
						pending_gain_d = gain;
					end
					default: begin
						state_d = state_q;
					end
				endcase
			end
			psga_pkg::REQ_GATE_OFF: begin
				case (state_q)
					psga_pkg::GATE_TO_ON: begin
						state_d = psga_pkg::GATE_OFF;
					end
					psga_pkg::GATE_ON, psga_pkg::GATE_CHANGE_GAIN: begin
						state_d = psga_pkg::GATE_TO_OFF;
					end
					default: begin
						state_d = state_q;
					end
				endcase
			end
			psga_pkg::REQ_SAMPLE: begin
				state_d      = state_r;
				last_phase_d = pint;
			end
			default: begin
				state_d = state_q;
			end
		endcase
	end

	// Drive the amplifier from the post-restart state
	always_comb begin
		amp.en   = state_r inside {psga_pkg::GATE_ON, psga_pkg::GATE_TO_OFF,
			psga_pkg::GATE_CHANGE_GAIN};
		amp.gain = active_gain_d;
	end

	// Hold state until a transaction leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= psga_pkg::GATE_OFF;
			active_gain_q  <= '0;
			pending_gain_q <= '0;
			last_phase_q   <= '0;
		end else if (fire) begin
			state_q        <= state_d;
			pending_gain_q <= pending_gain_d;
			last_phase_q   <= last_phase_d;
			if (req == psga_pkg::REQ_SAMPLE) begin
				active_gain_q <= active_gain_d;
			end
		end
	end

`ifndef SYNTHESIS
	a_active_gain_src: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(active_gain_q) |->
		($past(state_q) == psga_pkg::GATE_TO_ON || $past(state_q) == psga_pkg::GATE_CHANGE_GAIN))
		else $error("active gain changed outside a pending gain update");
	a_enter_on: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == psga_pkg::GATE_ON && $past(state_q) != psga_pkg::GATE_ON) |->
		($past(state_q) == psga_pkg::GATE_TO_ON || $past(state_q) == psga_pkg::GATE_CHANGE_GAIN))
		else $error("gate entered on from an unexpected state");
	a_pending_src: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(pending_gain_q) |-> $past(fire && req == psga_pkg::REQ_GATE_ON))
		else $error("pending gain changed without a gate-on request");
`endif

endmodule

// File: design/psga_scale.sv
// Divide the gained magnitude by unity gain and saturate to 16 bits signed.
module psga_scale (
	input  logic [psga_pkg::MAG_W-1:0]          mag,
	input  logic                                neg,
	output logic signed [psga_pkg::SAMPLE_W-1:0] result
);

	logic [psga_pkg::PROD_W-1:0] prod;
	logic [psga_pkg::QUO_W-1:0]  quo;
	logic [psga_pkg::QUO_W-1:0]  neg_quo;

	// Reciprocal multiply gives the exact floor quotient by 127
	assign prod    = psga_pkg::PROD_W'(mag) * psga_pkg::PROD_W'(psga_pkg::RECIP_127);
	assign quo     = prod[psga_pkg::RECIP_SHIFT +: psga_pkg::QUO_W];
	assign neg_quo = (~quo) + psga_pkg::QUO_W'(1);

	// Clamp toward the nearest bound, keep truncation toward zero
	always_comb begin
		if (neg) begin
			if (quo > psga_pkg::NEG_LIMIT) begin
				result = {1'b1, {(psga_pkg::SAMPLE_W-1){1'b0}}};
			end else begin
				result = neg_quo[psga_pkg::SAMPLE_W-1:0];
			end
		end else begin
			if (quo > psga_pkg::POS_LIMIT) begin
				result = {1'b0, {(psga_pkg::SAMPLE_W-1){1'b1}}};
			end else begin
				result = quo[psga_pkg::SAMPLE_W-1:0];
			end
		end
	end

endmodule

// File: design/phase_synced_gated_amplifier_top.sv
// Top level of the phase-synced gated amplifier: input, multiply and output stages.
//
// Channel   Direction  Handshake             Payload
// in        sink       in_valid / in_ready   req_type, sample_in, phase_int, phase_frac, gain
// out       source     out_valid / out_ready sample_out
//
// One transaction per cycle sustained while out_ready is high; a sample passes the input
// register, the gain multiply register, then the output register before it shows up on out.
// Gate and gain requests update state as they leave the input register and give no result.
// Reset clears all valid bits, the gate state, both gains and the stored phase.
// Each stage advances when the stage after it is empty or advancing, so a stalled
// output fills the pipeline before in_ready drops.
module phase_synced_gated_amplifier_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [psga_pkg::REQ_W-1:0]           req_type,
	input  logic signed [psga_pkg::SAMPLE_W-1:0] sample_in,
	input  logic [psga_pkg::PHASE_W-1:0]         phase_int,
	input  logic [psga_pkg::PHASE_W-1:0]         phase_frac,
	input  logic [psga_pkg::GAIN_W-1:0]          gain,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [psga_pkg::SAMPLE_W-1:0] sample_out
);

	logic                                 valid_s1;
	logic [psga_pkg::REQ_W-1:0]           req_s1;
	logic signed [psga_pkg::SAMPLE_W-1:0] sample_s1;
	logic [psga_pkg::PHASE_W-1:0]         pint_s1;
	logic [psga_pkg::PHASE_W-1:0]         pfrac_s1;
	logic [psga_pkg::GAIN_W-1:0]          gain_s1;

	logic                                 valid_s2;
	logic [psga_pkg::MAG_W-1:0]           mag_s2;
	logic                                 neg_s2;

	logic                                 out_valid_q;
	logic signed [psga_pkg::SAMPLE_W-1:0] sample_out_q;

	logic                                 en_out;
	logic                                 en_s2;
	logic                                 en_s1;
	logic                                 fire_s1;
	psga_pkg::amp_t                       amp;
	logic [psga_pkg::SAMPLE_W:0]          abs_in;
	logic [psga_pkg::MAG_W-1:0]           mag;
	logic signed [psga_pkg::SAMPLE_W-1:0] scaled;

	// Stage enables
	assign en_out   = !out_valid_q || out_ready;
	assign en_s2    = !valid_s2 || en_out;
	assign en_s1    = !valid_s1 || en_s2;
	assign fire_s1  = valid_s1 && en_s2;
	assign in_ready = en_s1;

	// Capture the input transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			req_s1    <= req_type;
			sample_s1 <= sample_in;
			pint_s1   <= phase_int;
			pfrac_s1  <= phase_frac;
			gain_s1   <= gain;
		end
	end

	psga_gate u_gate (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire_s1),
		.req        (req_s1),
		.phase_int  (pint_s1),
		.phase_frac (pfrac_s1),
		.gain       (gain_s1),
		.amp        (amp)
	);

	// Multiply the sample magnitude by the active gain
	assign abs_in = sample_s1[psga_pkg::SAMPLE_W-1] ?
		((~{sample_s1[psga_pkg::SAMPLE_W-1], sample_s1}) + (psga_pkg::SAMPLE_W+1)'(1)) :
		{1'b0, sample_s1};
	assign mag = amp.en ?
		(psga_pkg::MAG_W'(abs_in) * psga_pkg::MAG_W'(amp.gain)) : '0;

	// Advance samples into the multiply stage; drop gate requests and unused codes here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1 && (req_s1 == psga_pkg::REQ_SAMPLE);
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			mag_s2 <= mag;
			neg_s2 <= sample_s1[psga_pkg::SAMPLE_W-1];
		end
	end

	psga_scale u_scale (
		.mag    (mag_s2),
		.neg    (neg_s2),
		.result (scaled)
	);

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && valid_s2) begin
			sample_out_q <= scaled;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the phase-synced gated amplifier: scoreboard, stimulus and checks.
`timescale 1ns / 100ps

import psga_pkg::*;

// Track the gate state the way the block should and compare every output transaction
class amp_scoreboard;
	logic [GATE_W-1:0]          gate;
	logic [GAIN_W-1:0]          active_gain;
	logic [GAIN_W-1:0]          pending_gain;
	logic [PHASE_W-1:0]         prev_phase;
	logic signed [SAMPLE_W-1:0] expected_out[$];
	int                         mismatches;

	function new();
		gate         = GATE_OFF;
		active_gain  = '0;
		pending_gain = '0;
		prev_phase   = '0;
		mismatches   = 0;
	endfunction

	// Apply one accepted input transaction and queue the sample it should produce
	function void note_input(logic [REQ_W-1:0] req, logic signed [SAMPLE_W-1:0] smp,
			logic [PHASE_W-1:0] pint_raw, logic [PHASE_W-1:0] pfrac_raw,
			logic [GAIN_W-1:0] g);
		logic [PHASE_W-1:0]         pint;
		logic [PHASE_W-1:0]         pfrac;
		logic                       restart;
		int                         scaled;
		logic signed [SAMPLE_W-1:0] result;
		case (req)
			REQ_GATE_ON: begin
				case (gate)
					GATE_OFF: begin
						pending_gain = g;
						gate         = GATE_TO_ON;
					end
					GATE_ON, GATE_TO_OFF: begin
						pending_gain = g;
						gate         = GATE_CHANGE_GAIN;
					end
					GATE_TO_ON, GATE_CHANGE_GAIN: pending_gain = g;
					default: ;
				endcase
			end
			REQ_GATE_OFF: begin
				case (gate)
					GATE_TO_ON:                gate = GATE_OFF;
					GATE_ON, GATE_CHANGE_GAIN: gate = GATE_TO_OFF;
					default: ;
				endcase
			end
			REQ_SAMPLE: begin
				pint    = pint_raw & PHASE_INT_MASK;
				pfrac   = pfrac_raw & PHASE_FRAC_MASK;
				restart = (pint == '0 && pfrac == '0) || (pint < prev_phase);
				// Commit pending gate changes only on an oscillator restart
				if (restart) begin
					if (gate == GATE_TO_ON || gate == GATE_CHANGE_GAIN) begin
						active_gain = pending_gain;
						gate        = GATE_ON;
					end else if (gate == GATE_TO_OFF) begin
						gate = GATE_OFF;
					end
				end
				result = '0;
				if (gate == GATE_ON || gate == GATE_TO_OFF || gate == GATE_CHANGE_GAIN) begin
					scaled = int'(smp) * int'(active_gain) / 127;
					if (scaled > 32767)
						scaled = 32767;
					if (scaled < -32768)
						scaled = -32768;
					result = scaled[SAMPLE_W-1:0];
				end
				prev_phase = pint;
				expected_out.push_back(result);
			end
			default: ;
		endcase
	endfunction

	// Compare one output transaction with the oldest queued sample
	function void check_result(logic signed [SAMPLE_W-1:0] actual);
		logic signed [SAMPLE_W-1:0] exp_val;
		if (expected_out.size() == 0) begin
			$display("%0t: sample_out %0d arrived with none expected", $time, actual);
			mismatches++;
		end else begin
			exp_val = expected_out.pop_front();
			if (exp_val !== actual) begin
				$display("%0t: sample_out expected %0d, actual %0d", $time, exp_val, actual);
				mismatches++;
			end
		end
	endfunction
endclass

module tb_top;
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int ITEMS_PER_PHASE = 390;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic [REQ_W-1:0]           req_type = '0;
	logic signed [SAMPLE_W-1:0] sample_in = '0;
	logic [PHASE_W-1:0]         phase_int = '0;
	logic [PHASE_W-1:0]         phase_frac = '0;
	logic [GAIN_W-1:0]          gain = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_out;

	amp_scoreboard sb = new();
	int            sender_idle_pct = 0;
	int            receiver_stall_pct = 0;
	int            quiet_cycles = 0;
	logic [31:0]   osc_phase = '0;
	logic [31:0]   osc_step = 32'h0400_0000;

	phase_synced_gated_amplifier_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.sample_in  (sample_in),
		.phase_int  (phase_int),
		.phase_frac (phase_frac),
		.gain       (gain),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out)
	);

	always #6 clk = ~clk;

	// Stall the output at the rate of the current phase
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
	end

	// Observe both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_input(req_type, sample_in, phase_int, phase_frac, gain);
			if (out_valid && out_ready)
				sb.check_result(sample_out);
		end
	end

	// End the run when no transaction moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Offer one input transaction after a random gap and hold it until accepted
	task automatic send_item(input logic [REQ_W-1:0] req, input logic [SAMPLE_W-1:0] smp,
			input logic [PHASE_W-1:0] pint, input logic [PHASE_W-1:0] pfrac,
			input logic [GAIN_W-1:0] g);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= req;
		sample_in  <= smp;
		phase_int  <= pint;
		phase_frac <= pfrac;
		gain       <= g;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Mostly oscillator-driven samples, with gate requests, odd phases and unused codes mixed in
	task automatic random_item();
		int                 pick;
		logic [REQ_W-1:0]   req;
		logic [SAMPLE_W-1:0] smp;
		logic [PHASE_W-1:0] pint;
		logic [PHASE_W-1:0] pfrac;
		logic [GAIN_W-1:0]  g;
		pick  = $urandom_range(0, 99);
		smp   = SAMPLE_W'($urandom);
		pint  = PHASE_W'($urandom);
		pfrac = PHASE_W'($urandom);
		g     = GAIN_W'($urandom);
		if ($urandom_range(0, 9) == 0)
			smp = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
		if ($urandom_range(0, 199) == 0)
			osc_step = $urandom_range(32'h0200_0000, 32'h2000_0000);
		if (pick < 8) begin
			req = REQ_GATE_ON;
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 3))
					0: g = 8'd0;
					1: g = 8'd127;
					2: g = 8'd255;
					default: g = 8'd1;
				endcase
			end
		end else if (pick < 14) begin
			req = REQ_GATE_OFF;
		end else if (pick < 17) begin
			req = REQ_UNUSED;
		end else if (pick < 21) begin
			req = REQ_SAMPLE;
		end else if (pick < 23) begin
			req       = REQ_SAMPLE;
			osc_phase = '0;
			pint      = '0;
			pfrac     = '0;
		end else begin
			req           = REQ_SAMPLE;
			osc_phase     = osc_phase + osc_step;
			{pint, pfrac} = osc_phase;
		end
		send_item(req, smp, pint, pfrac, g);
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		osc_step           = $urandom_range(32'h0200_0000, 32'h2000_0000);
		repeat (count)
			random_item();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Gated off: phase zero restart, unused code, gate off with nothing to turn off
		send_item(REQ_SAMPLE, 16'd1000, 16'h0000, 16'h0000, 8'h00);
		send_item(REQ_UNUSED, 16'hffff, 16'hffff, 16'hffff, 8'hff);
		send_item(REQ_GATE_OFF, 16'h0000, 16'h0000, 16'h0000, 8'h00);
		// Cancel a pending turn-on, then turn on again and overwrite the gain
		send_item(REQ_GATE_ON, 16'h0000, 16'h0000, 16'h0000, 8'd127);
		send_item(REQ_GATE_OFF, 16'h0000, 16'h0000, 16'h0000, 8'h00);
		send_item(REQ_GATE_ON, 16'h0000, 16'h0000, 16'h0000, 8'd255);
		send_item(REQ_GATE_ON, 16'h0000, 16'h0000, 16'h0000, 8'd127);
		// No restart yet, so still silent; then integer part drops and the gate opens
		send_item(REQ_SAMPLE, 16'd12345, 16'd100, 16'd5, 8'h00);
		send_item(REQ_SAMPLE, 16'd500, 16'd50, 16'd0, 8'h00);
		send_item(REQ_SAMPLE, 16'h7fff, 16'd60, 16'hffff, 8'h00);
		send_item(REQ_SAMPLE, 16'h8000, 16'd70, 16'd0, 8'h00);
		// Gain change held until restart; a zero integer with nonzero fraction still drops
		send_item(REQ_GATE_ON, 16'h0000, 16'h0000, 16'h0000, 8'd255);
		send_item(REQ_GATE_ON, 16'h0000, 16'h0000, 16'h0000, 8'd254);
		send_item(REQ_SAMPLE, 16'h7fff, 16'd80, 16'd0, 8'h00);
		send_item(REQ_SAMPLE, 16'h0000, 16'd0, 16'd1, 8'h00);
		// Saturate both ways, then scale a small negative exactly
		send_item(REQ_SAMPLE, 16'h7fff, 16'd1, 16'd0, 8'h00);
		send_item(REQ_SAMPLE, 16'h8000, 16'd2, 16'd0, 8'h00);
		send_item(REQ_SAMPLE, 16'hffff, 16'd3, 16'd0, 8'h00);
		// Turning off keeps amplifying; gate on from to_off and off from change_gain
		send_item(REQ_GATE_OFF, 16'h0000, 16'h0000, 16'h0000, 8'h00);
		send_item(REQ_SAMPLE, 16'd100, 16'd4, 16'd0, 8'h00);
		send_item(REQ_GATE_ON, 16'h0000, 16'h0000, 16'h0000, 8'd0);
		send_item(REQ_GATE_OFF, 16'h0000, 16'h0000, 16'h0000, 8'h00);
		send_item(REQ_GATE_OFF, 16'h0000, 16'h0000, 16'h0000, 8'h00);
		send_item(REQ_SAMPLE, 16'd77, 16'd0, 16'd0, 8'h00);
		// Zero gain gives silence while on
		send_item(REQ_GATE_ON, 16'h0000, 16'h0000, 16'h0000, 8'd0);
		send_item(REQ_SAMPLE, 16'd1000, 16'd0, 16'd0, 8'h00);
		send_item(REQ_SAMPLE, 16'h8000, 16'hffff, 16'hffff, 8'h00);

		run_phase(0, 0, ITEMS_PER_PHASE);
		run_phase(47, 0, ITEMS_PER_PHASE);
		run_phase(0, 47, ITEMS_PER_PHASE);
		run_phase(34, 34, ITEMS_PER_PHASE);
		in_valid <= 1'b0;

		// Drain the pipeline, then keep watching for stray outputs
		while (sb.expected_out.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_out.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
